### src/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sem_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_DW = 11;
  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_IDX_HEIGHT = 1'b1;
  localparam logic [CFG_DW-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_DW-1:0] RESET_HEIGHT = 11'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int PIX_W = 24;
  localparam int CH_W  = 8;
  localparam logic [CH_W-1:0] MAG_SAT = 8'd255;
  // 4*n at or above 511^2 saturates the magnitude
  localparam logic [22:0] FOUR_SAT = 23'd261121;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_GRAD,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       load_grad;
    logic       load_sq;
    logic       root_step;
    logic [2:0] bit_idx;
  } lane_ctl_t;

endpackage

### src/sem_if.sv
// Valid/ready channel interfaces for pixel input and edge results.
interface sem_in_if;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [sem_pkg::CH_W-1:0] pixel_red;
  logic [sem_pkg::CH_W-1:0] pixel_green;
  logic [sem_pkg::CH_W-1:0] pixel_blue;
  modport source (output valid, operation, pixel_red, pixel_green, pixel_blue, input ready);
  modport sink   (input valid, operation, pixel_red, pixel_green, pixel_blue, output ready);
endinterface

interface sem_out_if;
  logic                    valid;
  logic                    ready;
  logic [sem_pkg::CH_W-1:0] edge_red;
  logic [sem_pkg::CH_W-1:0] edge_green;
  logic [sem_pkg::CH_W-1:0] edge_blue;
  logic                    frame_last;
  modport source (output valid, edge_red, edge_green, edge_blue, frame_last, input ready);
  modport sink   (input valid, edge_red, edge_green, edge_blue, frame_last, output ready);
endinterface

### src/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sem_lane.sv
// One color lane: Sobel gradients, squared sum, bit-serial rounded square root.
module sem_lane (
  input  logic                                 clk,
  input  sem_pkg::lane_ctl_t                   ctl,
  input  logic [8:0][sem_pkg::CH_W-1:0]        pix,
  output logic [sem_pkg::CH_W-1:0]             mag
);

  logic signed [11:0] gx_r, gy_r;
  logic [22:0]        four_r;
  logic [7:0]         k_r;
  logic               sat_r;

  logic [10:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [23:0] gx2, gy2;
  logic [23:0] sum;
  logic [7:0]  t;
  logic [8:0]  odd;
  logic [17:0] odd_sq;

  // pix index is row*3 + column
  always_comb begin
    gx_pos = 11'(pix[2]) + {2'b0, pix[5], 1'b0} + 11'(pix[8]);
    gx_neg = 11'(pix[0]) + {2'b0, pix[3], 1'b0} + 11'(pix[6]);
    gy_pos = 11'(pix[6]) + {2'b0, pix[7], 1'b0} + 11'(pix[8]);
    gy_neg = 11'(pix[0]) + {2'b0, pix[1], 1'b0} + 11'(pix[2]);
    gx2    = gx_r * gx_r;
    gy2    = gy_r * gy_r;
    sum    = $unsigned(gx2) + $unsigned(gy2);
    t      = k_r | (8'd1 << ctl.bit_idx);
    odd    = {t, 1'b0} - 9'd1;
    odd_sq = odd * odd;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_grad) begin
      gx_r <= $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
      gy_r <= $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    end
    if (ctl.load_sq) begin
      four_r <= {sum[20:0], 2'b00};
      sat_r  <= {sum[20:0], 2'b00} >= sem_pkg::FOUR_SAT;
      k_r    <= '0;
    end else if (ctl.root_step) begin
      if ({5'b0, odd_sq} <= four_r) begin
        k_r <= t;
      end
    end
  end

  assign mag = sat_r ? sem_pkg::MAG_SAT : k_r;

endmodule

### src/sobel_edge_magnitude_rgb_top.sv
// Top level: Sobel edge magnitude over an RGB raster stream.
//
// Pixels of one frame enter on in_ch in raster order (operation 0); after
// the last pixel the source sends width + 1 drain beats (operation 1).
// Each beat yields at most one result on out_ch; the result for a pixel
// appears with the beat one line plus one pixel later, and frame_last
// marks the frame's final result. Image width and height are written on
// the cfg_ port (index 0 width, 1 height) while the block is idle; any
// write restarts the frame. Out-of-range sizes clamp to 1..MAX.
// A beat that yields a result goes from acceptance through line store
// update, the gradients, the squares and the bit-serial square root in
// each of the three color lanes before its result is loaded into the
// output register. A beat with no result returns to idle after the line
// store update. The output register holds a result while out_ch is
// stalled; the next beat is accepted meanwhile, and its result waits in
// the lanes until the register frees.
// Reset sets 640x480, clears the window and counters; line store content
// is undefined but never reaches a result.
module sobel_edge_magnitude_rgb_top #(
  parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  sem_in_if.sink                    in_ch,
  sem_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [sem_pkg::CFG_IW-1:0] cfg_index,
  input  logic [sem_pkg::CFG_DW-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 3);
  localparam int PW = sem_pkg::PIX_W;
  localparam int CH = sem_pkg::CH_W;

  sem_pkg::state_t state_r, state_nxt;

  logic [sem_pkg::CFG_DW-1:0] cfg_w_r, cfg_h_r;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [PW-1:0] px_r;
  logic [PW-1:0] win_r [3][3];
  logic [8:0]    mask_r, mask_nxt;
  logic          last_r, last_nxt;
  logic          emit;
  logic [2:0]    bit_r;

  logic [PW-1:0] up_q, mid_q;
  logic          ram_re, ram_we;
  sem_pkg::lane_ctl_t ctl;
  logic [2:0][8:0][CH-1:0] lane_pix;
  logic [2:0][CH-1:0]      lane_mag;

  logic          out_valid_r;
  logic [CH-1:0] out_r_r, out_g_r, out_b_r;
  logic          out_last_r;
  logic          out_load;
  logic          in_acc;

  // Clamp configured sizes to 1..MAX
  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h_eff = RW'(1);
    end else if (32'(cfg_h_r) > MAX_HEIGHT) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(cfg_h_r);
    end
  end

  assign in_acc = in_ch.valid && in_ch.ready;

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(ram_we), .waddr(in_col_r), .wdata(mid_q),
    .re(ram_re), .raddr(in_col_r), .rdata(up_q)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(ram_we), .waddr(in_col_r), .wdata(px_r),
    .re(ram_re), .raddr(in_col_r), .rdata(mid_q)
  );

  // Position bookkeeping for the UPDATE cycle
  always_comb begin
    logic [WW-1:0] in_col_p1, out_col_p1;
    logic [RW:0]   out_row_p1;
    in_col_p1  = WW'(in_col_r) + WW'(1);
    out_col_p1 = WW'(out_col_r) + WW'(1);
    out_row_p1 = (RW+1)'(out_row_r) + (RW+1)'(1);
    emit = (in_row_r >= RW'(2)) || (in_row_r == RW'(1) && in_col_r != '0);
    if (in_col_p1 >= w_eff) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + RW'(1);
    end else begin
      in_col_nxt = CW'(in_col_p1);
      in_row_nxt = in_row_r;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mask_nxt[r*3+c] = ((r != 0) || (out_row_r != '0)) &&
                          ((r != 2) || (out_row_p1 < (RW+1)'(h_eff))) &&
                          ((c != 0) || (out_col_r != '0)) &&
                          ((c != 2) || (out_col_p1 < w_eff));
      end
    end
    last_nxt = (out_row_p1 >= (RW+1)'(h_eff)) && (out_col_p1 >= w_eff);
    if (out_col_p1 >= w_eff) begin
      out_col_nxt = '0;
      out_row_nxt = out_row_r + RW'(1);
    end else begin
      out_col_nxt = CW'(out_col_p1);
      out_row_nxt = out_row_r;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sem_pkg::ST_IDLE:   if (in_acc) state_nxt = sem_pkg::ST_UPDATE;
      sem_pkg::ST_UPDATE: state_nxt = emit ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
      sem_pkg::ST_GRAD:   state_nxt = sem_pkg::ST_SQUARE;
      sem_pkg::ST_SQUARE: state_nxt = sem_pkg::ST_ROOT;
      sem_pkg::ST_ROOT:   if (bit_r == '0) state_nxt = sem_pkg::ST_DONE;
      sem_pkg::ST_DONE:   if (out_load) state_nxt = sem_pkg::ST_IDLE;
      default:            state_nxt = sem_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ch.ready   = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    ctl.load_grad = 1'b0;
    ctl.load_sq   = 1'b0;
    ctl.root_step = 1'b0;
    ctl.bit_idx   = bit_r;
    out_load      = 1'b0;
    unique case (state_r)
      sem_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_re      = in_ch.valid;
      end
      sem_pkg::ST_UPDATE: ram_we        = 1'b1;
      sem_pkg::ST_GRAD:   ctl.load_grad = 1'b1;
      sem_pkg::ST_SQUARE: ctl.load_sq   = 1'b1;
      sem_pkg::ST_ROOT:   ctl.root_step = 1'b1;
      sem_pkg::ST_DONE:   out_load      = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sem_pkg::ST_IDLE;
      cfg_w_r     <= sem_pkg::RESET_WIDTH;
      cfg_h_r     <= sem_pkg::RESET_HEIGHT;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      out_valid_r <= 1'b0;
      bit_r       <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == sem_pkg::CFG_IDX_WIDTH) begin
          cfg_w_r <= cfg_wdata;
        end else begin
          cfg_h_r <= cfg_wdata;
        end
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else if (state_r == sem_pkg::ST_UPDATE) begin
        for (int r = 0; r < 3; r++) begin
          win_r[r][0] <= win_r[r][1];
          win_r[r][1] <= win_r[r][2];
        end
        win_r[0][2] <= up_q;
        win_r[1][2] <= mid_q;
        win_r[2][2] <= px_r;
        if (emit && last_nxt) begin
          // frame done: start over with the next beat
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else begin
          in_col_r <= in_col_nxt;
          in_row_r <= in_row_nxt;
          if (emit) begin
            out_col_r <= out_col_nxt;
            out_row_r <= out_row_nxt;
          end
        end
      end
      if (state_r == sem_pkg::ST_SQUARE) begin
        bit_r <= 3'd7;
      end else if (state_r == sem_pkg::ST_ROOT) begin
        bit_r <= bit_r - 3'd1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px_r <= (in_ch.operation == sem_pkg::OP_DRAIN) ? '0 :
              {in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue};
    end
    if (state_r == sem_pkg::ST_UPDATE) begin
      mask_r <= mask_nxt;
      last_r <= last_nxt;
    end
    if (out_load) begin
      out_r_r    <= lane_mag[0];
      out_g_r    <= lane_mag[1];
      out_b_r    <= lane_mag[2];
      out_last_r <= last_r;
    end
  end

  // Lane 0 red, 1 green, 2 blue; masked neighbors read as zero
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          lane_pix[ch][r*3+c] = mask_r[r*3+c] ? win_r[r][c][(2-ch)*CH +: CH] : '0;
        end
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    sem_lane u_lane (
      .clk(clk),
      .ctl(ctl),
      .pix(lane_pix[g]),
      .mag(lane_mag[g])
    );
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_red   = out_r_r;
  assign out_ch.edge_green = out_g_r;
  assign out_ch.edge_blue  = out_b_r;
  assign out_ch.frame_last = out_last_r;

`ifndef SYNTHESIS
  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == sem_pkg::ST_UPDATE)
    else $error("accepted beat did not enter update");

  a_no_emit_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sem_pkg::ST_UPDATE && in_row_r == '0 && !cfg_we)
    |=> state_r == sem_pkg::ST_IDLE)
    else $error("result produced from the first row");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sem_pkg::ST_DONE)
    else $error("output loaded outside done state");
`endif

endmodule

### tb/tb_top.sv
// Testbench for the RGB Sobel edge magnitude block against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = sem_pkg::MAX_WIDTH_DEF;
  localparam int MAXH = sem_pkg::MAX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 30;
  localparam int RANDOM_ITEMS = 900;

  typedef struct packed {
    logic [sem_pkg::CH_W-1:0] red;
    logic [sem_pkg::CH_W-1:0] green;
    logic [sem_pkg::CH_W-1:0] blue;
    logic                     last;
  } edge_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [sem_pkg::CFG_IW-1:0] cfg_index;
  logic [sem_pkg::CFG_DW-1:0] cfg_wdata;

  sem_in_if  in_ch ();
  sem_out_if out_ch ();

  sobel_edge_magnitude_rgb_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [sem_pkg::CFG_DW-1:0] width_reg, height_reg;
  logic [sem_pkg::PIX_W-1:0]  upper_line [MAXW];
  logic [sem_pkg::PIX_W-1:0]  middle_line [MAXW];
  logic [sem_pkg::PIX_W-1:0]  win [3][3];
  int unsigned in_col, in_row, out_col, out_row;

  edge_t edge_expected[$];
  int    fail_count;
  int    cycle_count;
  int    items_sent;
  bit    idle_en;
  int    hold_cycles;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // round(sqrt(n)) saturated at 255, built up bit by bit
  function automatic logic [sem_pkg::CH_W-1:0] round_root(longint unsigned n);
    longint unsigned four, t, odd;
    int unsigned k;
    four = 4 * n;
    k = 0;
    if (four >= 511 * 511) return sem_pkg::MAG_SAT;
    for (int b = 7; b >= 0; b--) begin
      t = k | (1 << b);
      odd = 2 * t - 1;
      if (odd * odd <= four) k = t;
    end
    return k[sem_pkg::CH_W-1:0];
  endfunction

  function automatic void clear_positions();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  function automatic void sobel_predict(logic op, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b);
    int side [3] = '{-1, 0, 1};
    int wt [3] = '{1, 2, 1};
    int unsigned w, h, idx, shift;
    logic [sem_pkg::PIX_W-1:0] px, up, mid;
    bit emit, last;
    bit rowok [3];
    bit colok [3];
    int gx, gy, v;
    logic [sem_pkg::CH_W-1:0] mag [3];
    edge_t e;
    w = clamp_dim(width_reg, MAXW);
    h = clamp_dim(height_reg, MAXH);
    px = (op == sem_pkg::OP_DRAIN) ? '0 : {r, g, b};
    idx = (in_col < MAXW) ? in_col : MAXW - 1;
    up = upper_line[idx];
    mid = middle_line[idx];
    upper_line[idx] = mid;
    middle_line[idx] = px;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = px;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    rowok[0] = out_row > 0; rowok[1] = 1'b1; rowok[2] = out_row + 1 < h;
    colok[0] = out_col > 0; colok[1] = 1'b1; colok[2] = out_col + 1 < w;
    for (int ch = 0; ch < 3; ch++) begin
      shift = 16 - 8 * ch;
      gx = 0; gy = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          if (rowok[i] && colok[j]) begin
            v = int'((win[i][j] >> shift) & 24'hFF);
            gx += side[j] * wt[i] * v;
            gy += side[i] * wt[j] * v;
          end
        end
      mag[ch] = round_root(longint'(gx * gx) + longint'(gy * gy));
    end
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    e.red = mag[0]; e.green = mag[1]; e.blue = mag[2]; e.last = last;
    edge_expected.push_back(e);
    if (last) clear_positions();
    else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    edge_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (edge_expected.size() == 0) begin
        $error("unexpected result beat");
        fail_count++;
      end else begin
        e = edge_expected.pop_front();
        if (out_ch.edge_red !== e.red) begin
          $error("edge_red expected %0d got %0d", e.red, out_ch.edge_red);
          fail_count++;
        end
        if (out_ch.edge_green !== e.green) begin
          $error("edge_green expected %0d got %0d", e.green, out_ch.edge_green);
          fail_count++;
        end
        if (out_ch.edge_blue !== e.blue) begin
          $error("edge_blue expected %0d got %0d", e.blue, out_ch.edge_blue);
          fail_count++;
        end
        if (out_ch.frame_last !== e.last) begin
          $error("frame_last expected %0d got %0d", e.last, out_ch.frame_last);
          fail_count++;
        end
      end
    end
  end

  // result receiver: random stalls, plus long hold-offs on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.pixel_red <= r;
    in_ch.pixel_green <= g;
    in_ch.pixel_blue <= b;
    do @(posedge clk); while (!in_ch.ready);
    sobel_predict(op, r, g, b);
    items_sent++;
  endtask

  task automatic send_random_pixel();
    send_beat(sem_pkg::OP_PIXEL, $urandom_range(0, 255), $urandom_range(0, 255),
              $urandom_range(0, 255));
  endtask

  task automatic send_drains(int unsigned n);
    repeat (n) send_beat(sem_pkg::OP_DRAIN, $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // hold input idle until every expected result is out and the lanes are empty
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (edge_expected.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [sem_pkg::CFG_IW-1:0] idx,
                           logic [sem_pkg::CFG_DW-1:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sem_pkg::CFG_IDX_WIDTH) width_reg = val;
    else height_reg = val;
    clear_positions();
    @(posedge clk);
  endtask

  task automatic set_size(int unsigned w, int unsigned h);
    write_reg(sem_pkg::CFG_IDX_WIDTH, w[sem_pkg::CFG_DW-1:0]);
    write_reg(sem_pkg::CFG_IDX_HEIGHT, h[sem_pkg::CFG_DW-1:0]);
  endtask

  task automatic test_small_frames();
    logic [7:0] v;
    // 3x3 checkerboard of full-scale values saturates the magnitude everywhere but the center
    set_size(3, 3);
    for (int i = 0; i < 9; i++) begin
      v = (i % 2) ? 8'hFF : 8'h00;
      send_beat(sem_pkg::OP_PIXEL, v, ~v, v);
    end
    // a pixel beat past the frame end acts as a drain
    send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    send_drains(3);
    // a drain inside the frame reads as a black pixel
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_beat(sem_pkg::OP_DRAIN, 8'hFF, 8'hFF, 8'hFF);
      else send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF);
    end
    send_drains(4);
    // zero sizes clamp to a single pixel
    set_size(0, 0);
    send_beat(sem_pkg::OP_PIXEL, 8'hFF, 8'h00, 8'h80);
    send_drains(2);
  endtask

  task automatic test_large_sizes();
    // height beyond range clamps to the maximum; run part of a tall column
    set_size(1, 2047);
    repeat (40) send_random_pixel();
  endtask

  task automatic test_restart();
    set_size(5, 4);
    repeat (12) send_random_pixel();
    write_reg(sem_pkg::CFG_IDX_WIDTH, 5);
    repeat (20) send_random_pixel();
    send_drains(6);
  endtask

  task automatic test_backpressure();
    set_size(8, 6);
    hold_cycles = 400;
    repeat (30) send_random_pixel();
    // pause until the pipeline has emptied, mid-frame
    in_ch.valid <= 1'b0;
    while (edge_expected.size() > 0) @(posedge clk);
    repeat (18) send_random_pixel();
    send_drains(9);
  endtask

  task automatic test_random_frames();
    int unsigned w, h, start, cut;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - start > RANDOM_ITEMS - 150) idle_en = 1'b0;
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_size(w, h);
      cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h) : w * h;
      for (int i = 0; i < cut; i++) begin
        if ($urandom_range(0, 19) == 0) send_drains(1);
        else send_random_pixel();
      end
      if (cut == w * h) begin
        for (int i = 0; i <= w; i++) begin
          if ($urandom_range(0, 7) == 0) send_random_pixel();
          else send_drains(1);
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = sem_pkg::CFG_IDX_WIDTH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = sem_pkg::OP_PIXEL;
    in_ch.pixel_red = '0;
    in_ch.pixel_green = '0;
    in_ch.pixel_blue = '0;
    fail_count = 0;
    cycle_count = 0;
    items_sent = 0;
    hold_cycles = 0;
    idle_en = 1'b1;
    width_reg = sem_pkg::RESET_WIDTH;
    height_reg = sem_pkg::RESET_HEIGHT;
    for (int i = 0; i < MAXW; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    clear_positions();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_small_frames();
    test_restart();
    test_backpressure();
    test_large_sizes();
    test_random_frames();

    wait_drained();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
